// ----- src/tlfu_pkg.sv -----
package tlfu_pkg;

    localparam int CMD_BITS = 2;
    localparam int KEY_BITS = 64;
    localparam int CNT_BITS = 4;
    localparam int PROBE_COUNT = 4;
    localparam int PROBE_BITS = 2;
    localparam int IN_DATA_BITS = 72;
    localparam int OUT_DATA_BITS = 8;

    localparam logic [CNT_BITS-1:0] CNT_MAX = 4'd15;

    localparam logic [CMD_BITS-1:0] CMD_INC = 2'd0;
    localparam logic [CMD_BITS-1:0] CMD_EST = 2'd1;
    localparam logic [CMD_BITS-1:0] CMD_AGE = 2'd2;

    // Probe p uses p times 0x9e3779b9, truncated to 32 bits.
    localparam logic [PROBE_COUNT-1:0][31:0] PROBE_KEY = {
        32'hdaa66d2b, 32'h3c6ef372, 32'h9e3779b9, 32'h00000000
    };

    typedef logic [1:0] t_alu_op;

    localparam t_alu_op ALU_ZERO = 2'd0;
    localparam t_alu_op ALU_INC  = 2'd1;
    localparam t_alu_op ALU_MIN  = 2'd2;
    localparam t_alu_op ALU_HALF = 2'd3;

    typedef struct packed {
        t_alu_op              op;
        logic [CNT_BITS-1:0]  a;
        logic [CNT_BITS-1:0]  b;
    } t_alu_req;

endpackage

// ----- src/tlfu_alu.sv -----
module tlfu_alu
    import tlfu_pkg::*;
(
    input  t_alu_req            i_req,
    output logic [CNT_BITS-1:0] o_result
);

    always_comb begin
        case (i_req.op)
            ALU_ZERO: o_result = '0;
            ALU_INC: begin
                if (i_req.a == CNT_MAX) begin
                    o_result = CNT_MAX;
                end else begin
                    o_result = i_req.a + 1'b1;
                end
            end
            ALU_MIN: begin
                if (i_req.a < i_req.b) begin
                    o_result = i_req.a;
                end else begin
                    o_result = i_req.b;
                end
            end
            ALU_HALF: o_result = i_req.a >> 1;
            default: o_result = '0;
        endcase
    end

endmodule

// ----- src/tlfu_ram.sv -----
module tlfu_ram
    import tlfu_pkg::*;
#(
    parameter int ADDR_BITS = 10
) (
    input  logic                 i_clk,
    input  logic                 i_we,
    input  logic [ADDR_BITS-1:0] i_addr,
    input  logic [CNT_BITS-1:0]  i_wdata,
    output logic [CNT_BITS-1:0]  o_rdata
);

    logic [CNT_BITS-1:0] r_mem [2**ADDR_BITS];
    logic [CNT_BITS-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_addr] <= i_wdata;
        end
        r_rdata <= r_mem[i_addr];
    end

    assign o_rdata = r_rdata;

endmodule

// ----- src/tinylfu_frequency_sketch_core.sv -----
// Count-min style frequency sketch of 2**INDEX_BITS saturating 4-bit counters held in one
// single-port table memory with a single saturating-increment, minimum and halving unit.
// Every probe takes a read state and then a write or compare state. An increment makes
// PROBE_COUNT probes, and an estimate makes PROBE_COUNT probes and then loads the result
// register, waiting while that register is full and not taken; an age request reads and halves every counter in turn.
// After reset the block clears the whole table before it takes a
// request. Input tready is high only while the sequencer is idle; a finished estimate
// waits in the output register, and the next request may be taken meanwhile.
module tinylfu_frequency_sketch_core
    import tlfu_pkg::*;
#(
    parameter int INDEX_BITS = 10
) (
    input  logic                     i_clk,
    input  logic                     i_rst_n,
    input  logic                     i_s_axis_tvalid,
    output logic                     o_s_axis_tready,
    // Fields from bit 0: cmd [1:0], key_hash [65:2], zero fill [71:66].
    input  logic [IN_DATA_BITS-1:0]  i_s_axis_tdata,
    output logic                     o_m_axis_tvalid,
    input  logic                     i_m_axis_tready,
    // Fields from bit 0: frequency [3:0], zero fill [7:4].
    output logic [OUT_DATA_BITS-1:0] o_m_axis_tdata
);

    localparam logic [2:0] ST_IDLE   = 3'd0;
    localparam logic [2:0] ST_CLEAR  = 3'd1;
    localparam logic [2:0] ST_RD     = 3'd2;
    localparam logic [2:0] ST_WR     = 3'd3;
    localparam logic [2:0] ST_AGE_RD = 3'd4;
    localparam logic [2:0] ST_AGE_WR = 3'd5;
    localparam logic [2:0] ST_OUT    = 3'd6;

    logic [2:0]            r_state, n_state;
    logic [CMD_BITS-1:0]   r_cmd, n_cmd;
    logic [INDEX_BITS-1:0] r_key, n_key;
    logic [PROBE_BITS-1:0] r_probe, n_probe;
    logic [INDEX_BITS-1:0] r_addr, n_addr;
    logic [CNT_BITS-1:0]   r_min, n_min;
    logic                  r_out_valid, n_out_valid;
    logic [CNT_BITS-1:0]   r_freq, n_freq;

    logic                  in_accept;
    logic [INDEX_BITS-1:0] probe_idx;
    logic                  ram_we;
    logic [INDEX_BITS-1:0] ram_addr;
    logic [CNT_BITS-1:0]   ram_rdata;
    t_alu_req              alu_req;
    logic [CNT_BITS-1:0]   alu_result;

    assign o_s_axis_tready = (r_state == ST_IDLE);
    assign in_accept       = i_s_axis_tvalid && o_s_axis_tready;
    assign probe_idx       = r_key ^ PROBE_KEY[r_probe][INDEX_BITS-1:0];
    assign o_m_axis_tvalid = r_out_valid;
    assign o_m_axis_tdata  = {{(OUT_DATA_BITS-CNT_BITS){1'b0}}, r_freq};

    tlfu_alu u_alu (
        .i_req    (alu_req),
        .o_result (alu_result)
    );

    tlfu_ram #(
        .ADDR_BITS (INDEX_BITS)
    ) u_ram (
        .i_clk   (i_clk),
        .i_we    (ram_we),
        .i_addr  (ram_addr),
        .i_wdata (alu_result),
        .o_rdata (ram_rdata)
    );

    always_comb begin
        n_state     = r_state;
        n_cmd       = r_cmd;
        n_key       = r_key;
        n_probe     = r_probe;
        n_addr      = r_addr;
        n_min       = r_min;
        n_out_valid = r_out_valid;
        n_freq      = r_freq;
        ram_we      = 1'b0;
        ram_addr    = probe_idx;
        alu_req.op  = ALU_ZERO;
        alu_req.a   = ram_rdata;
        alu_req.b   = r_min;

        if (r_out_valid && i_m_axis_tready) begin
            n_out_valid = 1'b0;
        end

        case (r_state)
            ST_IDLE: begin
                if (in_accept) begin
                    n_cmd   = i_s_axis_tdata[CMD_BITS-1:0];
                    n_key   = i_s_axis_tdata[CMD_BITS +: INDEX_BITS];
                    n_probe = '0;
                    n_addr  = '0;
                    n_min   = CNT_MAX;
                    case (i_s_axis_tdata[CMD_BITS-1:0])
                        CMD_INC, CMD_EST: n_state = ST_RD;
                        CMD_AGE:          n_state = ST_AGE_RD;
                        default:          n_state = ST_IDLE;
                    endcase
                end
            end
            ST_CLEAR: begin
                ram_we   = 1'b1;
                ram_addr = r_addr;
                n_addr   = r_addr + 1'b1;
                if (r_addr == {INDEX_BITS{1'b1}}) begin
                    n_state = ST_IDLE;
                end
            end
            ST_RD: begin
                n_state = ST_WR;
            end
            ST_WR: begin
                if (r_cmd == CMD_INC) begin
                    alu_req.op = ALU_INC;
                    ram_we     = 1'b1;
                end else begin
                    alu_req.op = ALU_MIN;
                    n_min      = alu_result;
                end
                n_probe = r_probe + 1'b1;
                if (r_probe == PROBE_BITS'(PROBE_COUNT - 1)) begin
                    n_state = (r_cmd == CMD_INC) ? ST_IDLE : ST_OUT;
                end else begin
                    n_state = ST_RD;
                end
            end
            ST_AGE_RD: begin
                ram_addr = r_addr;
                n_state  = ST_AGE_WR;
            end
            ST_AGE_WR: begin
                alu_req.op = ALU_HALF;
                ram_we     = 1'b1;
                ram_addr   = r_addr;
                n_addr     = r_addr + 1'b1;
                if (r_addr == {INDEX_BITS{1'b1}}) begin
                    n_state = ST_IDLE;
                end else begin
                    n_state = ST_AGE_RD;
                end
            end
            ST_OUT: begin
                if (!r_out_valid || i_m_axis_tready) begin
                    n_out_valid = 1'b1;
                    n_freq      = r_min;
                    n_state     = ST_IDLE;
                end
            end
            default: begin
                n_state = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= ST_CLEAR;
            r_probe     <= '0;
            r_addr      <= '0;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_probe     <= n_probe;
            r_addr      <= n_addr;
            r_out_valid <= n_out_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        r_cmd  <= n_cmd;
        r_key  <= n_key;
        r_min  <= n_min;
        r_freq <= n_freq;
    end

`ifndef SYNTH
    a_wr_after_rd: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == ST_WR) |-> ($past(r_state) == ST_RD))
        else $error("probe write or compare without a preceding read");

    a_we_states: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        ram_we |-> (r_state == ST_CLEAR || r_state == ST_AGE_WR
                    || (r_state == ST_WR && r_cmd == CMD_INC)))
        else $error("table written outside clear, age or increment");

    a_probe_idle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == ST_IDLE) |-> (r_probe == '0))
        else $error("probe counter not rewound at end of request");

    a_est_out: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $rose(r_out_valid) |-> ($past(r_state) == ST_OUT && r_cmd == CMD_EST))
        else $error("result produced for a request other than an estimate");
`endif

endmodule
